// ===== sv/lrc_pkg.sv =====
package lrc_pkg;

    localparam int WORD_W             = 64;
    localparam int SQ_W               = 10;
    localparam int NP_W               = 4;
    localparam int ROOT_W             = 9;
    localparam int WC_W               = 4;
    localparam int WC_MAX             = 15;
    localparam int DEF_MAX_LOG_DEGREE = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SQR,
        ST_HFORM,
        ST_GCD
    } state_t;

    typedef enum logic [1:0] {
        FIN_BAD,
        FIN_FULL,
        FIN_DA,
        FIN_DB
    } fin_kind_t;

    typedef struct packed {
        logic      load;
        logic      capture;
        logic      init;
        logic      sq_step;
        logic      h_form;
        logic      gcd_step;
        logic      finish;
        fin_kind_t kind;
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic n_zero;
        logic bit_last;
        logic sq_last;
        logic h_zero;
        logic a_zero;
        logic b_zero;
    } stat_t;

endpackage

// ===== sv/lrc_ctrl.sv =====
module lrc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           last_word,
    input  lrc_pkg::stat_t stat,
    output lrc_pkg::cmd_t  cmd,
    output logic           busy,
    output logic           done
);
    import lrc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.finish;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && last_word)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.bad)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.n_zero)
                begin
                    state_next = ST_HFORM;
                end
                else
                begin
                    state_next = ST_SQR;
                end
            end
            ST_SQR:
            begin
                if (stat.bit_last && stat.sq_last)
                begin
                    state_next = ST_HFORM;
                end
            end
            ST_HFORM:
            begin
                state_next = stat.h_zero ? ST_IDLE : ST_GCD;
            end
            ST_GCD:
            begin
                if (stat.a_zero || stat.b_zero)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load    = start;
                cmd.capture = start && last_word;
            end
            ST_CHECK:
            begin
                cmd.init   = !stat.bad;
                cmd.finish = stat.bad;
                cmd.kind   = FIN_BAD;
            end
            ST_SQR:
            begin
                cmd.sq_step = 1'b1;
            end
            ST_HFORM:
            begin
                cmd.h_form = !stat.h_zero;
                cmd.finish = stat.h_zero;
                cmd.kind   = FIN_FULL;
            end
            ST_GCD:
            begin
                if (stat.b_zero)
                begin
                    cmd.finish = 1'b1;
                    cmd.kind   = FIN_DA;
                end
                else if (stat.a_zero)
                begin
                    cmd.finish = 1'b1;
                    cmd.kind   = FIN_DB;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

// ===== sv/lrc_dp.sv =====
module lrc_dp #(
    parameter int MAX_LOG_DEGREE = lrc_pkg::DEF_MAX_LOG_DEGREE
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lrc_pkg::cmd_t               cmd,
    input  logic [lrc_pkg::WORD_W-1:0]  lam_word,
    input  logic [lrc_pkg::SQ_W-1:0]    squarings,
    input  logic [lrc_pkg::NP_W-1:0]    log_degree,
    output lrc_pkg::stat_t              stat,
    output logic [lrc_pkg::ROOT_W-1:0]  root_count,
    output logic                        invalid
);
    import lrc_pkg::*;

    localparam int SW    = ((1 << MAX_LOG_DEGREE) >> 6) + 1;
    localparam int W     = (1 << MAX_LOG_DEGREE) + 1;
    localparam int CW    = MAX_LOG_DEGREE + 1;
    localparam int FLATW = SW * WORD_W;

    logic [WORD_W-1:0] store_reg [SW];
    logic [WC_W-1:0]   wc_reg;
    logic              ovf_reg;
    logic [SQ_W-1:0]   n_reg;
    logic [NP_W-1:0]   np_reg;
    logic [SQ_W-1:0]   k_reg;
    logic [CW-1:0]     i_reg;
    logic [CW-1:0]     dlm1_reg;
    logic [W-1:0]      l_reg;
    logic [W-1:0]      p_reg;
    logic [W-1:0]      acc_reg;
    logic [W-1:0]      a_reg;
    logic [W-1:0]      b_reg;
    logic [CW-1:0]     da_reg;
    logic [CW-1:0]     db_reg;
    logic [ROOT_W-1:0] root_reg;
    logic              invalid_reg;

    logic [FLATW-1:0]       flat;
    logic [CW-1:0]          dl;
    logic                   range_bad;
    logic [W-1:0]           l_build;
    logic [W-1:0]           xred;
    logic [W-1:0]           h_val;
    logic [W-1:0]           acc_next;
    logic [CW+ROOT_W-1:0]   ext_dl;
    logic [CW+ROOT_W-1:0]   ext_da;
    logic [CW+ROOT_W-1:0]   ext_db;

    always_comb
    begin
        for (int w = 0; w < SW; w++)
        begin
            flat[w*WORD_W +: WORD_W] = store_reg[w];
        end
    end

    assign dl = CW'(1) << np_reg;

    always_comb
    begin
        range_bad = 1'b0;
        for (int j = 0; j < FLATW; j++)
        begin
            if (flat[j] && (j >= int'(dl)))
            begin
                range_bad = 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < W; j++)
        begin
            l_build[j] = flat[j] | (j == int'(dl));
        end
    end

    // The store holds lam for the whole job, so X mod L is available from it.
    always_comb
    begin
        xred = '0;
        if (np_reg == '0)
        begin
            xred[0] = flat[0];
        end
        else
        begin
            xred[1] = 1'b1;
        end
    end

    assign h_val = p_reg ^ xred;

    always_comb
    begin
        acc_next = {acc_reg[W-2:0], 1'b0};
        if (acc_reg[dlm1_reg])
        begin
            acc_next = acc_next ^ l_reg;
        end
        if (p_reg[i_reg])
        begin
            acc_next = acc_next ^ p_reg;
        end
    end

    assign stat.bad      = ovf_reg || (int'(np_reg) > MAX_LOG_DEGREE) || range_bad;
    assign stat.n_zero   = (n_reg == '0);
    assign stat.bit_last = (i_reg == '0);
    assign stat.sq_last  = (k_reg == SQ_W'(1));
    assign stat.h_zero   = (h_val == '0);
    assign stat.a_zero   = (a_reg == '0);
    assign stat.b_zero   = (b_reg == '0);

    assign ext_dl = {{ROOT_W{1'b0}}, dl};
    assign ext_da = {{ROOT_W{1'b0}}, da_reg};
    assign ext_db = {{ROOT_W{1'b0}}, db_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < SW; w++)
            begin
                store_reg[w] <= '0;
            end
            wc_reg  <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            for (int w = 0; w < SW; w++)
            begin
                store_reg[w] <= '0;
            end
            wc_reg  <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            if (int'(wc_reg) < SW)
            begin
                store_reg[int'(wc_reg)] <= lam_word;
            end
            else
            begin
                ovf_reg <= 1'b1;
            end
            if (int'(wc_reg) < WC_MAX)
            begin
                wc_reg <= wc_reg + WC_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            n_reg  <= squarings;
            np_reg <= log_degree;
        end
        if (cmd.init)
        begin
            l_reg    <= l_build;
            p_reg    <= xred;
            acc_reg  <= '0;
            k_reg    <= n_reg;
            i_reg    <= dl - CW'(1);
            dlm1_reg <= dl - CW'(1);
        end
        if (cmd.sq_step)
        begin
            if (i_reg == '0)
            begin
                p_reg   <= acc_next;
                acc_reg <= '0;
                i_reg   <= dlm1_reg;
                k_reg   <= k_reg - SQ_W'(1);
            end
            else
            begin
                acc_reg <= acc_next;
                i_reg   <= i_reg - CW'(1);
            end
        end
        if (cmd.h_form)
        begin
            a_reg  <= l_reg;
            b_reg  <= h_val;
            da_reg <= CW'(W - 1);
            db_reg <= CW'(W - 1);
        end
        if (cmd.gcd_step)
        begin
            if (a_reg[W-1] && b_reg[W-1])
            begin
                if (da_reg >= db_reg)
                begin
                    a_reg <= a_reg ^ b_reg;
                end
                else
                begin
                    b_reg <= b_reg ^ a_reg;
                end
            end
            else
            begin
                if (!a_reg[W-1])
                begin
                    a_reg  <= {a_reg[W-2:0], 1'b0};
                    da_reg <= da_reg - CW'(1);
                end
                if (!b_reg[W-1])
                begin
                    b_reg  <= {b_reg[W-2:0], 1'b0};
                    db_reg <= db_reg - CW'(1);
                end
            end
        end
        if (cmd.finish)
        begin
            unique case (cmd.kind)
                FIN_BAD:
                begin
                    root_reg    <= '0;
                    invalid_reg <= 1'b1;
                end
                FIN_FULL:
                begin
                    root_reg    <= ext_dl[ROOT_W-1:0];
                    invalid_reg <= 1'b0;
                end
                FIN_DA:
                begin
                    root_reg    <= ext_da[ROOT_W-1:0];
                    invalid_reg <= 1'b0;
                end
                FIN_DB:
                begin
                    root_reg    <= ext_db[ROOT_W-1:0];
                    invalid_reg <= 1'b0;
                end
                default:
                begin
                    root_reg    <= '0;
                    invalid_reg <= 1'b1;
                end
            endcase
        end
    end

    assign root_count = root_reg;
    assign invalid    = invalid_reg;

endmodule

// ===== sv/gf2_linearized_root_counter.sv =====
// Channel   Ports                                            Transfer
// -------   ----------------------------------------------   --------------------------
// input     lam_word, squarings, log_degree, last_word        start high while busy low
// result    root_count, invalid                               done high, one cycle only
//
// A word without last_word is taken into the word store. A last word starts a job of
// bit-serial modular squaring, one coefficient per cycle, repeated n times,
// followed by the aligned-shift gcd unit, in which both operands start aligned
// to the full width whatever np is.
// Reset clears the word store, the word count and the controller.
// The result is on the ports when done is high and holds until the next job ends;
// the receiver cannot stall, and a new word can be taken in that same cycle.
module gf2_linearized_root_counter #(
    parameter int MAX_LOG_DEGREE = lrc_pkg::DEF_MAX_LOG_DEGREE
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [lrc_pkg::WORD_W-1:0]  lam_word,
    input  logic [lrc_pkg::SQ_W-1:0]    squarings,
    input  logic [lrc_pkg::NP_W-1:0]    log_degree,
    input  logic                        last_word,
    output logic                        done,
    output logic [lrc_pkg::ROOT_W-1:0]  root_count,
    output logic                        invalid
);
    import lrc_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    lrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_word (last_word),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done)
    );

    lrc_dp #(
        .MAX_LOG_DEGREE (MAX_LOG_DEGREE)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .lam_word   (lam_word),
        .squarings  (squarings),
        .log_degree (log_degree),
        .stat       (stat),
        .root_count (root_count),
        .invalid    (invalid)
    );

endmodule
